@@ hw/rtl/byte_link_memory_server_assert.svh @@
// byte_link_memory_server_assert.svh: assertion macros for the byte link memory server.
// Expects clk and rst (synchronous, active high) in the scope of each use.
`ifndef BYTE_LINK_MEMORY_SERVER_ASSERT_SVH
`define BYTE_LINK_MEMORY_SERVER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define BLMS_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define BLMS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/blms_pkg.sv @@
// blms_pkg.sv: constants for the byte link memory server.
// No dependencies.
`timescale 1ns / 1ps

package blms_pkg;

  // Word store geometry
  localparam int MEM_WORDS = 262144;
  localparam int MEM_AW    = $clog2(MEM_WORDS);
  localparam logic [MEM_AW-1:0] CLR_LAST = MEM_AW'(MEM_WORDS - 1);

  localparam int ADDR_W = 18;
  localparam int WORD_W = 36;

  // Frame format
  localparam logic [3:0] MAX_PAYLOAD = 4'd9;
  localparam logic [7:0] TYPE_WRITE  = 8'd1;
  localparam logic [7:0] TYPE_READ   = 8'd2;

  // Reply bytes
  localparam logic [7:0] REPLY_HDR       = 8'd0;
  localparam logic [7:0] WRITE_REPLY_LEN = 8'd1;
  localparam logic [7:0] READ_REPLY_LEN  = 8'd6;
  localparam logic [7:0] ACK_CODE        = 8'd3;

  // Result kinds
  localparam logic [1:0] KIND_REPLY    = 2'd0;
  localparam logic [1:0] KIND_OVERSIZE = 2'd1;
  localparam logic [1:0] KIND_BADTYPE  = 2'd2;

  // Index of the final result of each reply
  localparam logic [2:0] STEP_LAST_ERR   = 3'd0;
  localparam logic [2:0] STEP_LAST_WRITE = 3'd2;
  localparam logic [2:0] STEP_LAST_READ  = 3'd7;

endpackage

@@ hw/rtl/byte_link_memory_server.sv @@
// byte_link_memory_server.sv: frame parser, word store and reply serializer.
// Depends on blms_pkg and byte_link_memory_server_assert.svh.
`timescale 1ns / 1ps

// Replies: the first result of a frame is offered in the cycle after the edge that takes
//   its closing byte; then one result per cycle while tx_stall is low (1, 3 or 8 results).
// Throughput: one byte per cycle. A byte that closes a frame waits while the previous
//   reply still drains through the single reply register; it passes at the edge that
//   takes that reply's last result.
// Reset: synchronous, active high. The word store is then zeroed one word per cycle, all
//   MEM_WORDS (262144) words, with rx_stall held high for the whole pass.
module byte_link_memory_server (
  input  logic       clk,
  input  logic       rst,
  // received byte channel
  input  logic       rx_valid,
  output logic       rx_stall,
  input  logic [7:0] rx_byte,
  // result channel
  output logic       tx_valid,
  input  logic       tx_stall,
  output logic [1:0] kind,
  output logic [7:0] tx_byte,
  output logic       last
);

  import blms_pkg::*;

  // Frame parser phases
  typedef enum logic [1:0] {
    PH_LEN_HI,
    PH_LEN_LO,
    PH_PAYLOAD,
    PH_CLOSED
  } phase_t;

  // Pending reply held in the reply register
  typedef enum logic [1:0] {
    JOB_OVERSIZE,
    JOB_BADTYPE,
    JOB_WRITE,
    JOB_READ
  } job_mode_t;

  // ---------------------------------------------------------------------------
  // State
  // ---------------------------------------------------------------------------
  phase_t      phase, phase_next;
  logic [7:0]  len_hi, len_hi_next;     // high length byte of the frame in progress
  logic [3:0]  flen, flen_next;         // payload length, 1..9 while collecting
  logic [3:0]  taken, taken_next;       // payload bytes collected
  logic [7:0]  payload [9];

  logic        job_valid, job_valid_next;
  job_mode_t   job_mode, job_mode_next;
  logic [2:0]  step, step_next;         // index of the result being offered

  logic              clr_active;        // store clearing pass after reset
  logic [MEM_AW-1:0] clr_addr;

  logic [WORD_W-1:0] mem [MEM_WORDS];
  logic [WORD_W-1:0] rd_q;

  // ---------------------------------------------------------------------------
  // Frame decode
  // ---------------------------------------------------------------------------
  logic [15:0]       len_full;
  logic [3:0]        taken_inc;
  logic              len_oversize;
  logic              len_zero;
  logic              completes;         // this byte closes a frame or the link
  logic [7:0]        eff [9];           // payload as it stands with this byte in place
  logic [23:0]       addr_raw;
  logic [39:0]       data_raw;
  logic [MEM_AW-1:0] req_addr;
  logic [WORD_W-1:0] req_data;
  job_mode_t         serve_mode;
  logic              rx_fire;
  logic              tx_fire;
  logic              job_load;
  logic [2:0]        job_last_step;

  assign len_full     = {len_hi, rx_byte};
  assign taken_inc    = taken + 4'd1;
  assign len_oversize = len_full > {12'd0, MAX_PAYLOAD};
  assign len_zero     = len_full == 16'd0;

  always_comb begin
    completes = 1'b0;
    if (phase == PH_LEN_LO) begin
      completes = len_oversize || len_zero;
    end else if (phase == PH_PAYLOAD) begin
      completes = taken_inc >= flen;
    end
  end

  // Missing payload bytes read as zero: the payload is cleared at frame start.
  always_comb begin
    for (int i = 0; i < 9; i++) begin
      if (phase == PH_LEN_LO) begin
        eff[i] = 8'd0;
      end else if (taken == 4'(i)) begin
        eff[i] = rx_byte;
      end else begin
        eff[i] = payload[i];
      end
    end
  end

  assign addr_raw = {eff[3], eff[2], eff[1]};
  assign data_raw = {eff[8], eff[7], eff[6], eff[5], eff[4]};
  assign req_addr = addr_raw[MEM_AW-1:0];
  assign req_data = data_raw[WORD_W-1:0];

  always_comb begin
    if (phase == PH_LEN_LO && len_oversize) begin
      serve_mode = JOB_OVERSIZE;
    end else if (eff[0] == TYPE_WRITE) begin
      serve_mode = JOB_WRITE;
    end else if (eff[0] == TYPE_READ) begin
      serve_mode = JOB_READ;
    end else begin
      serve_mode = JOB_BADTYPE;
    end
  end

  // A closing byte needs the reply register free, or freed by the last result
  // transfer at this same edge; other bytes pass except during reset and the clearing pass.
  assign tx_fire  = tx_valid && !tx_stall;
  assign rx_stall = rst || clr_active || (job_valid && completes && !(tx_fire && last));
  assign rx_fire  = rx_valid && !rx_stall;
  assign job_load = rx_fire && completes;

  always_comb begin
    unique case (job_mode)
      JOB_WRITE: job_last_step = STEP_LAST_WRITE;
      JOB_READ:  job_last_step = STEP_LAST_READ;
      default:   job_last_step = STEP_LAST_ERR;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Parser and reply control
  // ---------------------------------------------------------------------------
  always_comb begin
    phase_next     = phase;
    len_hi_next    = len_hi;
    flen_next      = flen;
    taken_next     = taken;
    job_valid_next = job_valid;
    job_mode_next  = job_mode;
    step_next      = step;

    if (rx_fire) begin
      unique case (phase)
        PH_LEN_HI: begin
          len_hi_next = rx_byte;
          phase_next  = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          taken_next = 4'd0;
          flen_next  = rx_byte[3:0];
          if (len_oversize) begin
            phase_next = PH_CLOSED;
          end else if (len_zero) begin
            phase_next = PH_LEN_HI;
          end else begin
            phase_next = PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          taken_next = taken_inc;
          if (completes) begin
            phase_next = PH_LEN_HI;
          end
        end
        PH_CLOSED: begin
          phase_next = PH_CLOSED;     // link stays closed until reset
        end
        default: begin
          phase_next = PH_CLOSED;
        end
      endcase
    end

    if (tx_fire) begin
      if (step == job_last_step) begin
        job_valid_next = 1'b0;
      end else begin
        step_next = step + 3'd1;
      end
    end

    if (job_load) begin
      job_valid_next = 1'b1;
      job_mode_next  = serve_mode;
      step_next      = 3'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_LEN_HI;
      len_hi     <= 8'd0;
      flen       <= 4'd0;
      taken      <= 4'd0;
      job_valid  <= 1'b0;
      job_mode   <= JOB_BADTYPE;
      step       <= 3'd0;
      clr_active <= 1'b1;
      clr_addr   <= '0;
    end else begin
      phase     <= phase_next;
      len_hi    <= len_hi_next;
      flen      <= flen_next;
      taken     <= taken_next;
      job_valid <= job_valid_next;
      job_mode  <= job_mode_next;
      step      <= step_next;
      if (clr_active) begin
        clr_addr <= clr_addr + MEM_AW'(1);
        if (clr_addr == CLR_LAST) begin
          clr_active <= 1'b0;
        end
      end
    end
  end

  // Payload bytes; cleared at each frame start.
  always_ff @(posedge clk) begin
    if (rx_fire && phase == PH_LEN_LO) begin
      for (int i = 0; i < 9; i++) begin
        payload[i] <= 8'd0;
      end
    end else if (rx_fire && phase == PH_PAYLOAD && taken < MAX_PAYLOAD) begin
      payload[taken] <= rx_byte;
    end
  end

  // ---------------------------------------------------------------------------
  // Word store: single port, clearing pass has priority (no frames run then)
  // ---------------------------------------------------------------------------
  logic              mem_we;
  logic              mem_re;
  logic [MEM_AW-1:0] mem_addr;
  logic [WORD_W-1:0] mem_wdata;

  assign mem_we    = clr_active || (job_load && serve_mode == JOB_WRITE);
  assign mem_re    = job_load && serve_mode == JOB_READ;
  assign mem_addr  = clr_active ? clr_addr : req_addr;
  assign mem_wdata = clr_active ? '0 : req_data;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
  end

  // Read word held for the whole read reply.
  always_ff @(posedge clk) begin
    if (mem_re) begin
      rd_q <= mem[mem_addr];
    end
  end

  // ---------------------------------------------------------------------------
  // Result fields, from the reply register, step count and read word only
  // ---------------------------------------------------------------------------
  assign tx_valid = job_valid;

  always_comb begin
    kind    = KIND_REPLY;
    tx_byte = 8'd0;
    last    = step == job_last_step;
    unique case (job_mode)
      JOB_OVERSIZE: kind = KIND_OVERSIZE;
      JOB_BADTYPE:  kind = KIND_BADTYPE;
      JOB_WRITE: begin
        case (step)
          3'd0:    tx_byte = REPLY_HDR;
          3'd1:    tx_byte = WRITE_REPLY_LEN;
          default: tx_byte = ACK_CODE;
        endcase
      end
      JOB_READ: begin
        case (step)
          3'd0:    tx_byte = REPLY_HDR;
          3'd1:    tx_byte = READ_REPLY_LEN;
          3'd2:    tx_byte = ACK_CODE;
          3'd3:    tx_byte = rd_q[7:0];
          3'd4:    tx_byte = rd_q[15:8];
          3'd5:    tx_byte = rd_q[23:16];
          3'd6:    tx_byte = rd_q[31:24];
          default: tx_byte = {4'd0, rd_q[35:32]};
        endcase
      end
      default: kind = KIND_BADTYPE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
`include "byte_link_memory_server_assert.svh"

  `BLMS_ASSERT_NEXT(a_closed_sticks, phase == PH_CLOSED, phase == PH_CLOSED, "link reopened")
  `BLMS_ASSERT_SAME(a_step_range, job_valid, step <= job_last_step, "reply step overran")
  `BLMS_ASSERT_NEXT(a_reply_ends, tx_fire && last, !job_valid || step == 3'd0, "reply outlived its last transfer")
  `BLMS_ASSERT_SAME(a_clear_full, $fell(clr_active), $past(clr_addr) == CLR_LAST, "short clear")

endmodule

@@ test/byte_link_memory_server_checker.sv @@
// byte_link_memory_server_checker.sv: watches both channels of the byte link memory server,
// predicts every result from the accepted bytes and compares each result transfer.
// Depends on blms_pkg.
`timescale 1ns / 1ps

module byte_link_memory_server_checker (
  input  logic       clk,
  input  logic       rst,
  input  logic       rx_valid,
  input  logic       rx_stall,
  input  logic [7:0] rx_byte,
  input  logic       tx_valid,
  input  logic       tx_stall,
  input  logic [1:0] kind,
  input  logic [7:0] tx_byte,
  input  logic       last,
  output int         mismatches,
  output int         pending
);

  import blms_pkg::*;

  typedef enum logic [1:0] {LEN_HI, LEN_LO, BODY, CLOSED} link_phase_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
    logic       last;
  } reply_t;

  link_phase_t       phase;
  logic [15:0]       frame_len;
  logic [3:0]        taken;
  logic [7:0]        body [9];
  logic [WORD_W-1:0] words [int];   // missing key reads as a cleared word
  reply_t            replies_due [$];

  initial begin
    mismatches = 0;
    pending    = 0;
  end

  task report_mismatch(input string msg);
    if (mismatches < 40) begin
      $display("%0t ns: mismatch: %s", $time, msg);
    end
    mismatches++;
  endtask

  function void push_reply(input logic [1:0] k, input logic [7:0] d, input logic l);
    replies_due.push_back('{k, d, l});
  endfunction

  // Decode a finished payload, update the word store and queue the replies.
  task serve_request();
    logic [ADDR_W-1:0] addr;
    logic [WORD_W-1:0] word;
    int                idx;
    addr = {body[3][1:0], body[2], body[1]};
    word = {body[8][3:0], body[7], body[6], body[5], body[4]};
    idx  = addr % MEM_WORDS;
    if (body[0] == TYPE_WRITE) begin
      words[idx] = word;
      push_reply(KIND_REPLY, REPLY_HDR, 1'b0);
      push_reply(KIND_REPLY, WRITE_REPLY_LEN, 1'b0);
      push_reply(KIND_REPLY, ACK_CODE, 1'b1);
    end else if (body[0] == TYPE_READ) begin
      word = words.exists(idx) ? words[idx] : '0;
      push_reply(KIND_REPLY, REPLY_HDR, 1'b0);
      push_reply(KIND_REPLY, READ_REPLY_LEN, 1'b0);
      push_reply(KIND_REPLY, ACK_CODE, 1'b0);
      for (int i = 0; i < 5; i++) begin
        push_reply(KIND_REPLY, 8'(word >> (8 * i)), i == 4);
      end
    end else begin
      push_reply(KIND_BADTYPE, 8'h00, 1'b1);
    end
  endtask

  always @(posedge clk) begin
    reply_t want;
    if (rst) begin
      phase     = LEN_HI;
      frame_len = '0;
      taken     = '0;
      for (int i = 0; i < 9; i++) body[i] = '0;
      words.delete();
      replies_due.delete();
    end else begin
      // results first: a byte taken at this edge cannot have caused one yet
      if (tx_valid === 1'b1 && tx_stall === 1'b0) begin
        if (replies_due.size() == 0) begin
          report_mismatch($sformatf("unexpected result kind %0d byte %02h last %0d",
                                    kind, tx_byte, last));
        end else begin
          want = replies_due.pop_front();
          if (kind !== want.kind)
            report_mismatch($sformatf("kind %0d, want %0d", kind, want.kind));
          if (tx_byte !== want.data)
            report_mismatch($sformatf("tx_byte %02h, want %02h", tx_byte, want.data));
          if (last !== want.last)
            report_mismatch($sformatf("last %0d, want %0d", last, want.last));
        end
      end
      if (rx_valid === 1'b1 && rx_stall === 1'b0) begin
        case (phase)
          LEN_HI: begin
            frame_len = {rx_byte, 8'h00};
            phase     = LEN_LO;
          end
          LEN_LO: begin
            frame_len[7:0] = rx_byte;
            if (frame_len > MAX_PAYLOAD) begin
              phase = CLOSED;
              push_reply(KIND_OVERSIZE, 8'h00, 1'b1);
            end else begin
              for (int i = 0; i < 9; i++) body[i] = '0;
              taken = '0;
              if (frame_len == 0) begin
                phase = LEN_HI;
                serve_request();
              end else begin
                phase = BODY;
              end
            end
          end
          BODY: begin
            if (taken < MAX_PAYLOAD) body[taken] = rx_byte;
            taken = taken + 4'd1;
            if (taken >= frame_len) begin
              phase = LEN_HI;
              serve_request();
            end
          end
          default: ;  // link closed: bytes are dropped until reset
        endcase
      end
    end
    pending <= replies_due.size();
  end

endmodule

@@ test/testbench.sv @@
// testbench.sv: top of the byte link memory server testbench; drives framed requests
// with random gaps and stalls, and gives the verdict from the checker's counts.
// Depends on blms_pkg, byte_link_memory_server and byte_link_memory_server_checker.
`timescale 1ns / 1ps

module testbench;
  import blms_pkg::*;

  // which side a gap is drawn for
  localparam int SENDER   = 0;
  localparam int RECEIVER = 1;

  // random part stops once this many bytes have gone in
  localparam int RANDOM_BYTES = 470;

  logic       clk = 1'b0;
  logic       rst;
  logic       rx_valid;
  logic       rx_stall;
  logic [7:0] rx_byte;
  logic       tx_valid;
  logic       tx_stall;
  logic [1:0] kind;
  logic [7:0] tx_byte;
  logic       last;

  int          mismatches;
  int          pending;
  int          bytes_sent;
  int          calm_left [2];   // transfers left in a stretch with no idling, per side
  logic [17:0] hot_addr [8];    // small address pool so that reads hit earlier writes

  always #5 clk = ~clk;

  byte_link_memory_server u_top (
    .clk      (clk),
    .rst      (rst),
    .rx_valid (rx_valid),
    .rx_stall (rx_stall),
    .rx_byte  (rx_byte),
    .tx_valid (tx_valid),
    .tx_stall (tx_stall),
    .kind     (kind),
    .tx_byte  (tx_byte),
    .last     (last)
  );

  byte_link_memory_server_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .rx_valid   (rx_valid),
    .rx_stall   (rx_stall),
    .rx_byte    (rx_byte),
    .tx_valid   (tx_valid),
    .tx_stall   (tx_stall),
    .kind       (kind),
    .tx_byte    (tx_byte),
    .last       (last),
    .mismatches (mismatches),
    .pending    (pending)
  );

  // Idle cycles before the next transfer on one side. More than half the draws give no
  // gap, the rest a gap drawn at random; now and then a side runs a stretch of back-to-back
  // transfers so that full-rate behavior is exercised too.
  function automatic int draw_gap(input int side);
    if (calm_left[side] > 0) begin
      calm_left[side]--;
      return 0;
    end
    if ($urandom_range(0, 31) == 0) begin
      calm_left[side] = $urandom_range(8, 40);
      return 0;
    end
    if ($urandom_range(0, 1) == 1) return 0;
    return $urandom_range(0, 19);
  endfunction

  // One byte transfer on the receive channel. Valid is raised without looking at
  // stall, and the byte holds still until the edge that takes it.
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = draw_gap(SENDER);
    if (gap > 0) begin
      rx_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    rx_valid <= 1'b1;
    rx_byte  <= b;
    @(posedge clk);
    while (rx_stall !== 1'b0) @(posedge clk);
    bytes_sent++;
  endtask

  // Length header (high byte always zero here) then the first len payload bytes.
  task automatic send_frame(input logic [7:0] len, input logic [7:0] body [9]);
    send_byte(8'h00);
    send_byte(len);
    for (int i = 0; i < len; i++) send_byte(body[i]);
  endtask

  // Mostly well-formed writes and reads with random content; some frames carry an
  // arbitrary type byte, some are cut short so the tail of the payload reads as zero.
  task automatic send_random_frame();
    logic [7:0]  body [9];
    logic [17:0] addr;
    logic [7:0]  len;
    int          pick;
    for (int i = 0; i < 9; i++) body[i] = 8'($urandom_range(0, 255));
    pick = $urandom_range(0, 99);
    if (pick < 45) body[0] = TYPE_WRITE;
    else if (pick < 90) body[0] = TYPE_READ;
    if ($urandom_range(0, 9) < 7) addr = hot_addr[$urandom_range(0, 7)];
    else addr = 18'($urandom);
    body[1]      = addr[7:0];
    body[2]      = addr[15:8];
    body[3][1:0] = addr[17:16];   // upper bits of this byte stay random: must be dropped
    if ($urandom_range(0, 9) < 8) begin
      len = (body[0] == TYPE_READ && $urandom_range(0, 1) == 1) ? 8'd4 : 8'd9;
    end else begin
      len = 8'($urandom_range(0, MAX_PAYLOAD));
    end
    send_frame(len, body);
  endtask

  // Result side: a fresh stall draw for every result transfer.
  initial begin
    int gap;
    tx_stall <= 1'b0;
    forever begin
      gap = draw_gap(RECEIVER);
      if (gap > 0) begin
        tx_stall <= 1'b1;
        repeat (gap) @(posedge clk);
      end
      tx_stall <= 1'b0;
      @(posedge clk);
      while (!(tx_valid === 1'b1 && tx_stall === 1'b0)) @(posedge clk);
    end
  end

  // Stimulus and verdict.
  initial begin
    logic [7:0] body [9];
    logic [7:0] len_hi;
    logic [7:0] len_lo;
    rst        <= 1'b1;
    rx_valid   <= 1'b0;
    rx_byte    <= 8'h00;
    bytes_sent = 0;
    calm_left  = '{0, 0};
    hot_addr[0] = 18'h00000;
    hot_addr[1] = 18'h3FFFF;
    for (int i = 2; i < 8; i++) hot_addr[i] = 18'($urandom);
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    // The store clear pass after reset holds rx_stall high; send_byte just waits it out.

    // Directed part.
    // Full-length write of all ones: top address, extra address and data bits masked off.
    body = '{TYPE_WRITE, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
    send_frame(8'd9, body);
    // Read it back with a short frame: the data bytes past the length are don't-care.
    body = '{TYPE_READ, 8'hFF, 8'hFF, 8'h03, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
    send_frame(8'd4, body);
    // One-byte read: address bytes missing, so word 0, still cleared from reset.
    body = '{TYPE_READ, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
    send_frame(8'd1, body);
    // Unknown message type at the top of the byte range.
    body = '{8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
    send_frame(8'd1, body);
    // Zero-length frame: served at once as type 0, an unknown type.
    send_byte(8'h00);
    send_byte(8'h00);

    // Random part.
    while (bytes_sent < RANDOM_BYTES) send_random_frame();

    // An oversize length closes the link for good, so it comes last; the trailing
    // bytes must be swallowed with no result.
    len_hi = 8'($urandom_range(0, 255));
    len_lo = (len_hi == 8'h00) ? 8'($urandom_range(MAX_PAYLOAD + 1, 255))
                               : 8'($urandom_range(0, 255));
    send_byte(len_hi);
    send_byte(len_lo);
    repeat (6) send_byte(8'($urandom_range(0, 255)));
    rx_valid <= 1'b0;

    // Drain: wait for the last expected result, then some quiet cycles to catch
    // anything extra the block might still send.
    for (int n = 0; n < 5000 && pending != 0; n++) @(posedge clk);
    repeat (40) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Run limit: clear pass plus the slowest legal run, with a wide margin.
  initial begin
    #20_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
